// File: src/kpd_pkg.sv
package kpd_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;
    localparam int ROW_LIM = (ROWS < 4) ? ROWS : 4;
    localparam int COL_LIM = (COLS < 4) ? COLS : 4;
    localparam int MAX_EVENTS = 4;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [2:0] ROWS_RESET = 3'd4;
    localparam logic [2:0] COLS_RESET = 3'd4;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_ROWS     = 2'd1,
        CFG_COLS     = 2'd2
    } t_cfg_addr;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_SCAN     = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DOWN     = 2'd1,
        EV_UP       = 2'd2,
        EV_SPURIOUS = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [2:0]  rows_used;
        logic [2:0]  cols_used;
    } t_cfg;

    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_EVENTS-1:0][1:0]  kinds;
        logic [MAX_EVENTS-1:0][3:0]  keys;
        logic [3:0]                  drive;
        logic [15:0]                 bounce;
        logic [15:0]                 round;
    } t_batch;

    function automatic logic [2:0] clamp_dim(input logic [2:0] v, input logic [2:0] lim);
        logic [2:0] res;
        if (v == 3'd0) begin
            res = 3'd1;
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: src/kpd_if.sv
interface kpd_item_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_levels;

    modport source (output valid, output row_levels, input ready);
    modport sink (input valid, input row_levels, output ready);
endinterface

interface kpd_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  column_drive;
    logic [1:0]  event_kind;
    logic [3:0]  key_index;
    logic [15:0] bounce_count;
    logic [15:0] round_number;
    logic        last;

    modport source (output valid, output column_drive, output event_kind, output key_index,
                    output bounce_count, output round_number, output last, input ready);
    modport sink (input valid, input column_drive, input event_kind, input key_index,
                  input bounce_count, input round_number, input last, output ready);
endinterface

interface kpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// File: src/kpd_regs.sv
module kpd_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kpd_cfg_if.sink       i_cfg,
    output kpd_pkg::t_cfg o_cfg
);
    import kpd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.rows_used <= ROWS_RESET;
            r_cfg.cols_used <= COLS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg.data;
                CFG_ROWS:     r_cfg.rows_used <= i_cfg.data[2:0];
                CFG_COLS:     r_cfg.cols_used <= i_cfg.data[2:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// File: src/kpd_step.sv
module kpd_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kpd_pkg::t_cfg   i_cfg,
    input  logic            i_fire,
    input  logic [3:0]      i_row_levels,
    output kpd_pkg::t_batch o_batch
);
    import kpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ref, n_ref;
    logic        r_ref_valid, n_ref_valid;
    logic [15:0] r_quiet, n_quiet;
    logic [15:0] r_bounce, n_bounce;
    logic [15:0] r_round, n_round;
    logic [1:0]  r_scan_col, n_scan_col;
    logic [15:0] r_keys, n_keys;
    logic        r_change, n_change;

    logic [2:0]  rows;
    logic [2:0]  cols;
    logic [3:0]  rmask;
    logic [3:0]  all_cols;
    logic [3:0]  sample;
    logic [15:0] need;
    logic [15:0] quiet_inc;
    logic [3:0]  base;
    logic [3:0]  key;
    logic [1:0]  sc_next;
    logic [2:0]  nev;
    logic [3:0]  drive;
    logic [MAX_EVENTS-1:0][1:0] kinds;
    logic [MAX_EVENTS-1:0][3:0] keys;

    always_comb begin
        n_phase = r_phase;
        n_ref = r_ref;
        n_ref_valid = r_ref_valid;
        n_quiet = r_quiet;
        n_bounce = r_bounce;
        n_round = r_round;
        n_scan_col = r_scan_col;
        n_keys = r_keys;
        n_change = r_change;

        rows = clamp_dim(i_cfg.rows_used, 3'(ROW_LIM));
        cols = clamp_dim(i_cfg.cols_used, 3'(COL_LIM));
        for (int r = 0; r < 4; r++) begin
            rmask[r] = 3'(r) < rows;
            all_cols[r] = 3'(r) < cols;
        end
        sample = i_row_levels & rmask;
        need = (i_cfg.debounce_ticks == 16'd0) ? 16'd1 : i_cfg.debounce_ticks;
        quiet_inc = (r_quiet != 16'hFFFF) ? r_quiet + 16'd1 : r_quiet;
        base = 4'(r_scan_col) * 4'(rows);
        key = base;
        sc_next = r_scan_col;
        nev = 3'd0;
        drive = all_cols;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            kinds[i] = EV_NONE;
            keys[i] = 4'd0;
        end

        case (r_phase)
            PH_SCAN: begin
                if ({1'b0, r_scan_col} < cols) begin
                    for (int r = 0; r < 4; r++) begin
                        key = base + 4'(r);
                        if (3'(r) < rows && sample[r] != r_keys[key]) begin
                            kinds[nev[1:0]] = sample[r] ? EV_DOWN : EV_UP;
                            keys[nev[1:0]] = key;
                            nev = nev + 3'd1;
                            n_keys[key] = ~r_keys[key];
                            n_change = 1'b1;
                        end
                    end
                    sc_next = r_scan_col + 2'd1;
                end
                n_scan_col = sc_next;
                if (sc_next != 2'd0 && {1'b0, sc_next} < cols) begin
                    drive = 4'b0001 << sc_next;
                end else begin
                    if (!n_change) begin
                        kinds[0] = EV_SPURIOUS;
                        nev = 3'd1;
                    end
                    n_phase = PH_IDLE;
                    n_scan_col = 2'd0;
                    n_change = 1'b0;
                end
            end
            PH_DEBOUNCE: begin
                if (sample != r_ref) begin
                    n_ref = sample;
                    n_quiet = 16'd0;
                    if (r_bounce != 16'hFFFF) begin
                        n_bounce = r_bounce + 16'd1;
                    end
                end else begin
                    n_quiet = quiet_inc;
                    if (quiet_inc >= need) begin
                        n_round = r_round + 16'd1;
                        n_phase = PH_SCAN;
                        n_scan_col = 2'd0;
                        n_change = 1'b0;
                        n_quiet = 16'd0;
                        drive = 4'b0001;
                    end
                end
            end
            default: begin
                if (!r_ref_valid) begin
                    n_ref = sample;
                    n_ref_valid = 1'b1;
                end else if (sample != r_ref) begin
                    n_ref = sample;
                    n_phase = PH_DEBOUNCE;
                    n_quiet = 16'd0;
                    n_bounce = 16'd0;
                end
            end
        endcase

        o_batch.count = (nev == 3'd0) ? 3'd1 : nev;
        o_batch.kinds = kinds;
        o_batch.keys = keys;
        o_batch.drive = drive;
        o_batch.bounce = n_bounce;
        o_batch.round = n_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ref <= 4'd0;
            r_ref_valid <= 1'b0;
            r_quiet <= 16'd0;
            r_bounce <= 16'd0;
            r_round <= 16'd0;
            r_scan_col <= 2'd0;
            r_keys <= 16'd0;
            r_change <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_ref <= n_ref;
            r_ref_valid <= n_ref_valid;
            r_quiet <= n_quiet;
            r_bounce <= n_bounce;
            r_round <= n_round;
            r_scan_col <= n_scan_col;
            r_keys <= n_keys;
            r_change <= n_change;
        end
    end

endmodule

// File: src/kpd_outq.sv
module kpd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  kpd_pkg::t_batch i_batch,
    output logic            o_can_load,
    kpd_result_if.source    o_result
);
    import kpd_pkg::*;

    logic                       r_valid;
    logic [2:0]                 r_left;
    logic [MAX_EVENTS-1:0][1:0] r_kinds;
    logic [MAX_EVENTS-1:0][3:0] r_keys;
    logic [3:0]                 r_drive;
    logic [15:0]                r_bounce;
    logic [15:0]                r_round;
    logic                       xfer;
    logic                       is_last;

    assign is_last = r_left == 3'd1;
    assign xfer = r_valid && o_result.ready;
    assign o_can_load = !r_valid || (xfer && is_last);

    assign o_result.valid = r_valid;
    assign o_result.column_drive = r_drive;
    assign o_result.event_kind = r_kinds[0];
    assign o_result.key_index = r_keys[0];
    assign o_result.bounce_count = r_bounce;
    assign o_result.round_number = r_round;
    assign o_result.last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left <= i_batch.count;
        end else if (xfer) begin
            r_valid <= !is_last;
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kinds <= i_batch.kinds;
            r_keys <= i_batch.keys;
            r_drive <= i_batch.drive;
            r_bounce <= i_batch.bounce;
            r_round <= i_batch.round;
        end else if (xfer) begin
            r_kinds <= {2'b00, r_kinds[MAX_EVENTS-1:1]};
            r_keys <= {4'b0000, r_keys[MAX_EVENTS-1:1]};
        end
    end

endmodule

// File: src/matrix_keypad_debounce_scanner_unit.sv
// Channel   Dir  Payload                                              Transfer
// i_item    in   row_levels                                           valid && ready
// o_result  out  column_drive event_kind key_index bounce_count       valid && ready
//                round_number last
// i_cfg     in   addr data (0 debounce_ticks, 1 rows_used, 2 cols_used) valid (ready high)
//
// A tick is evaluated in the cycle it is accepted and its results appear from the
// next cycle on, one result per cycle while o_result is ready, through the output register.
// A tick causing n results (1 to 4) holds the output until all n have transferred; the next
// tick is accepted in the cycle the final result transfers.
// Synchronous active-low reset restores register defaults and clears all state but the output payload registers.
// A stalled result keeps the next tick waiting; configuration writes never stall.
module matrix_keypad_debounce_scanner_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    kpd_item_if.sink  i_item,
    kpd_result_if.source o_result,
    kpd_cfg_if.sink   i_cfg
);
    import kpd_pkg::*;

    t_cfg   cfg;
    t_batch batch;
    logic   can_load;
    logic   fire;

    assign i_item.ready = can_load;
    assign fire = i_item.valid && can_load;

    kpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    kpd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_fire       (fire),
        .i_row_levels (i_item.row_levels),
        .o_batch      (batch)
    );

    kpd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

    a_tick_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_result.valid)
        else $error("accepted tick produced no result");

    a_ready_only_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> (!o_result.valid || o_result.last))
        else $error("tick accepted while earlier results are pending");

    a_lone_kinds_are_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.event_kind == EV_NONE ||
                            o_result.event_kind == EV_SPURIOUS))
        |-> (o_result.last && o_result.key_index == 4'd0))
        else $error("none or spurious result not alone");

    a_non_last_is_key_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.last)
        |-> (o_result.event_kind == EV_DOWN || o_result.event_kind == EV_UP))
        else $error("non-final result is not a key event");

endmodule

// File: tb/sv/kpd_event_checker.sv
`timescale 1ns / 100ps

module kpd_event_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kpd_item_if   item_ch,
    kpd_result_if res_ch,
    kpd_cfg_if    cfg_ch,
    output int    o_errors,
    output int    o_pending,
    output int    o_ticks,
    output int    o_results,
    output int    o_downs,
    output int    o_ups,
    output int    o_spurious
);
    import kpd_pkg::*;

    typedef struct packed {
        logic [3:0]  drive;
        t_event_kind kind;
        logic [3:0]  key;
        logic [15:0] bounce;
        logic [15:0] round;
        logic        last;
    } t_key_result;

    t_key_result expected_events[$];

    t_cfg        cfg_q;
    t_phase      phase_q;
    logic [3:0]  ref_rows;
    logic        ref_ok;
    logic [15:0] quiet_q;
    logic [15:0] bounce_q;
    logic [15:0] round_q;
    logic [1:0]  col_q;
    logic [15:0] key_state_q;
    logic        change_q;

    int err_count = 0;
    int tick_count = 0;
    int result_count = 0;
    int down_count = 0;
    int up_count = 0;
    int spurious_count = 0;

    function automatic int span(input logic [2:0] v, input int lim);
        if (v == 3'd0) begin
            return 1;
        end
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        if (err_count < 40) begin
            $display("kpd check at %0t: %s expected %0h, got %0h", $realtime, what, want, got);
        end
        err_count++;
    endtask

    task automatic scan_tick(input logic [3:0] levels);
        int          rows;
        int          cols;
        int          n;
        int          key;
        logic [3:0]  sample;
        logic [3:0]  drive;
        logic [15:0] need;
        t_event_kind kinds [4];
        logic [3:0]  keys [4];
        rows = span(cfg_q.rows_used, ROW_LIM);
        cols = span(cfg_q.cols_used, COL_LIM);
        sample = levels & 4'((1 << rows) - 1);
        need = (cfg_q.debounce_ticks == 16'd0) ? 16'd1 : cfg_q.debounce_ticks;
        drive = 4'((1 << cols) - 1);
        n = 0;
        case (phase_q)
            PH_SCAN: begin
                if (int'(col_q) < cols) begin
                    for (int r = 0; r < rows; r++) begin
                        key = int'(col_q) * rows + r;
                        if (sample[r] != key_state_q[key]) begin
                            kinds[n] = sample[r] ? EV_DOWN : EV_UP;
                            keys[n] = 4'(key);
                            n++;
                            key_state_q[key] = sample[r];
                            change_q = 1'b1;
                        end
                    end
                    col_q = col_q + 2'd1;
                end
                if (col_q != 2'd0 && int'(col_q) < cols) begin
                    drive = 4'd1 << col_q;
                end else begin
                    if (!change_q) begin
                        kinds[n] = EV_SPURIOUS;
                        keys[n] = 4'd0;
                        n++;
                    end
                    phase_q = PH_IDLE;
                    col_q = 2'd0;
                    change_q = 1'b0;
                end
            end
            PH_DEBOUNCE: begin
                if (sample != ref_rows) begin
                    ref_rows = sample;
                    quiet_q = 16'd0;
                    if (bounce_q != 16'hFFFF) begin
                        bounce_q++;
                    end
                end else begin
                    if (quiet_q != 16'hFFFF) begin
                        quiet_q++;
                    end
                    if (quiet_q >= need) begin
                        round_q++;
                        phase_q = PH_SCAN;
                        col_q = 2'd0;
                        change_q = 1'b0;
                        quiet_q = 16'd0;
                        drive = 4'd1;
                    end
                end
            end
            default: begin
                if (!ref_ok) begin
                    ref_rows = sample;
                    ref_ok = 1'b1;
                end else if (sample != ref_rows) begin
                    ref_rows = sample;
                    phase_q = PH_DEBOUNCE;
                    quiet_q = 16'd0;
                    bounce_q = 16'd0;
                end
            end
        endcase
        if (n == 0) begin
            kinds[0] = EV_NONE;
            keys[0] = 4'd0;
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            expected_events.push_back('{drive, kinds[i], keys[i], bounce_q, round_q,
                                        (i == n - 1)});
        end
    endtask

    task automatic check_result();
        t_key_result want;
        result_count++;
        case (res_ch.event_kind)
            EV_DOWN:     down_count++;
            EV_UP:       up_count++;
            EV_SPURIOUS: spurious_count++;
            default: ;
        endcase
        if (expected_events.size() == 0) begin
            report("result with nothing pending, kind", 16'd0, 16'(res_ch.event_kind));
            return;
        end
        want = expected_events.pop_front();
        if (res_ch.column_drive !== want.drive) begin
            report("column_drive", 16'(want.drive), 16'(res_ch.column_drive));
        end
        if (res_ch.event_kind !== want.kind) begin
            report("event_kind", 16'(want.kind), 16'(res_ch.event_kind));
        end
        if (res_ch.key_index !== want.key) begin
            report("key_index", 16'(want.key), 16'(res_ch.key_index));
        end
        if (res_ch.bounce_count !== want.bounce) begin
            report("bounce_count", want.bounce, res_ch.bounce_count);
        end
        if (res_ch.round_number !== want.round) begin
            report("round_number", want.round, res_ch.round_number);
        end
        if (res_ch.last !== want.last) begin
            report("last", 16'(want.last), 16'(res_ch.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q.debounce_ticks = DEBOUNCE_RESET;
            cfg_q.rows_used = ROWS_RESET;
            cfg_q.cols_used = COLS_RESET;
            phase_q = PH_IDLE;
            ref_rows = 4'd0;
            ref_ok = 1'b0;
            quiet_q = 16'd0;
            bounce_q = 16'd0;
            round_q = 16'd0;
            col_q = 2'd0;
            key_state_q = 16'd0;
            change_q = 1'b0;
            expected_events.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_result();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.addr)
                    CFG_DEBOUNCE: cfg_q.debounce_ticks = cfg_ch.data;
                    CFG_ROWS:     cfg_q.rows_used = cfg_ch.data[2:0];
                    CFG_COLS:     cfg_q.cols_used = cfg_ch.data[2:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                tick_count++;
                scan_tick(item_ch.row_levels);
            end
        end
        o_errors <= err_count;
        o_pending <= expected_events.size();
        o_ticks <= tick_count;
        o_results <= result_count;
        o_downs <= down_count;
        o_ups <= up_count;
        o_spurious <= spurious_count;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import kpd_pkg::*;

    localparam int LIMIT = 2_000_000;
    localparam int OPENING_LEN = 20;
    localparam logic [3:0] OPENING_TICKS [OPENING_LEN] = '{
        4'h0, 4'hF, 4'h3, 4'h3, 4'hF, 4'h0, 4'h5, 4'hA,
        4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
        4'h3, 4'h3, 4'h0, 4'h0, 4'h0, 4'h0
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic recv_ready = 1'b0;
    int   recv_stall_pct = 0;
    int   send_gap_pct = 0;
    int   cycle_count = 0;
    int   cfg_changes = 0;
    int   eff_rows = 4;
    int   eff_cols = 4;
    int   eff_wait = 20;
    logic [3:0] line_rows = 4'd0;

    int chk_errors;
    int chk_pending;
    int chk_ticks;
    int chk_results;
    int chk_downs;
    int chk_ups;
    int chk_spurious;

    kpd_item_if   item_ch ();
    kpd_result_if res_ch ();
    kpd_cfg_if    cfg_ch ();

    assign res_ch.ready = recv_ready;

    matrix_keypad_debounce_scanner_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    kpd_event_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .item_ch    (item_ch),
        .res_ch     (res_ch),
        .cfg_ch     (cfg_ch),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_ticks    (chk_ticks),
        .o_results  (chk_results),
        .o_downs    (chk_downs),
        .o_ups      (chk_ups),
        .o_spurious (chk_spurious)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        recv_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycle_count == LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results pending.", chk_pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_tick(input logic [3:0] levels);
        while ($urandom_range(99) < send_gap_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.row_levels <= levels;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= addr;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] deb, input logic [2:0] rows,
                              input logic [2:0] cols);
        settle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_ROWS, 16'(rows));
        write_reg(CFG_COLS, 16'(cols));
        cfg_changes++;
        eff_wait = (deb == 16'd0) ? 1 : int'(deb);
        eff_rows = (rows == 3'd0) ? 1 : ((int'(rows) > ROW_LIM) ? ROW_LIM : int'(rows));
        eff_cols = (cols == 3'd0) ? 1 : ((int'(cols) > COL_LIM) ? COL_LIM : int'(cols));
    endtask

    task automatic run_keypad(input int budget);
        int         sent;
        int         bounces;
        logic [3:0] mask;
        logic [3:0] target;
        sent = 0;
        while (sent < budget) begin
            mask = 4'((1 << eff_rows) - 1);
            if ($urandom_range(99) < 15) begin
                target = 4'($urandom);
                send_tick(target);
                sent++;
                line_rows = target & mask;
            end else begin
                repeat ($urandom_range(2)) begin
                    send_tick(line_rows | (4'($urandom) & ~mask));
                    sent++;
                end
                target = line_rows ^ (4'($urandom_range(1, 15)) & mask);
                if (target == line_rows) begin
                    target = line_rows ^ 4'd1;
                end
                send_tick(target | (4'($urandom) & ~mask));
                sent++;
                bounces = $urandom_range(3);
                repeat (bounces) begin
                    send_tick(4'($urandom));
                    sent++;
                end
                if (bounces != 0) begin
                    send_tick(target);
                    sent++;
                end
                repeat (eff_wait) begin
                    send_tick(target | (4'($urandom) & ~mask));
                    sent++;
                end
                repeat (eff_cols) begin
                    send_tick(4'($urandom));
                    sent++;
                end
                line_rows = target & mask;
            end
        end
    endtask

    task automatic random_phase(input int items);
        repeat (4) begin
            set_config(16'($urandom_range(4)), 3'($urandom_range(7)), 3'($urandom_range(7)));
            run_keypad(items / 4);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.row_levels = 4'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = CFG_DEBOUNCE;
        cfg_ch.data = 16'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 13;
        recv_stall_pct <= 56;

        set_config(16'd1, 3'd4, 3'd4);
        for (int i = 0; i < OPENING_LEN; i++) begin
            send_tick(OPENING_TICKS[i]);
        end

        set_config(16'hFFFF, 3'd7, 3'd0);
        send_tick(4'hC);
        send_tick(4'h5);
        send_tick(4'h5);
        settle();
        write_reg(CFG_DEBOUNCE, 16'd0);
        send_tick(4'h5);
        send_tick(4'hF);

        set_config(16'd1, 3'd4, 3'd4);
        send_tick(4'hA);
        send_tick(4'hA);
        send_tick(4'hF);
        settle();
        write_reg(CFG_COLS, 16'd1);
        eff_cols = 1;
        send_tick(4'h0);
        line_rows = 4'hA;

        random_phase(96);
        send_gap_pct = 56;
        recv_stall_pct <= 13;
        random_phase(96);
        send_gap_pct = 0;
        recv_stall_pct <= 0;
        random_phase(96);

        settle();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d ticks and %0d results: %0d key down, %0d key up, %0d spurious.",
                 chk_ticks, chk_results, chk_downs, chk_ups, chk_spurious);
        $display("Ran %0d register settings, including clamped sizes and zero debounce.",
                 cfg_changes);
        if (chk_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
